/* design/tlpm_pkg.sv */
// tlpm_pkg: types, sizes and codes shared by the trie lookup block
// used by tlpm_ctrl, tlpm_datapath and trie_longest_prefix_match
package tlpm_pkg;

    localparam int NODE_COUNT = 4096;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int FREE_BITS  = NODE_BITS + 1;
    localparam int PORT_BITS  = 8;
    localparam int ADDR_BITS  = 32;
    localparam int LEN_BITS   = 6;
    localparam int MAX_DEPTH  = 32;
    localparam int OUT_BITS   = 8;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [ADDR_BITS-1:0] address;
        logic [LEN_BITS-1:0]  prefix_length;
        logic [OUT_BITS-1:0]  port;
    } item_t;

    typedef struct packed {
        logic                found;
        logic [OUT_BITS-1:0] out_port;
        logic                status;
    } result_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] left;
        logic [NODE_BITS-1:0] right;
        logic                 valid;
        logic [PORT_BITS-1:0] port;
    } node_t;

    typedef struct packed {
        logic start;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

endpackage

/* design/tlpm_datapath.sv */
// tlpm_datapath: node pool memory, root node registers, walk registers and result register
// depends on tlpm_pkg; driven by tlpm_ctrl through dp_cmd_t / dp_status_t
module tlpm_datapath
    import tlpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  dp_cmd_t    cmd,
    output dp_status_t sts,
    output result_t    result
);

    node_t mem [NODE_COUNT];
    node_t rd_data_reg;

    node_t                root_reg, root_next;
    logic [FREE_BITS-1:0] free_reg, free_next;
    logic [NODE_BITS-1:0] node_reg, node_next;
    logic                 fresh_reg, fresh_next;
    logic [LEN_BITS-1:0]  level_reg, level_next;
    logic [LEN_BITS-1:0]  len_reg, len_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic                 kind_reg, kind_next;
    logic [PORT_BITS-1:0] port_reg, port_next;
    logic                 hit_reg, hit_next;
    logic [PORT_BITS-1:0] best_reg, best_next;
    result_t              result_reg, result_next;

    node_t                cur;
    node_t                wr_data;
    logic [NODE_BITS-1:0] child;
    logic                 child_null;
    logic                 pool_full;
    logic                 at_end;
    logic                 lookup_done;
    logic                 done;
    logic                 hit_now;
    logic                 walk_hit;
    logic [PORT_BITS-1:0] walk_port;
    logic                 wr_en;
    logic                 rd_en;
    logic                 move;

    // current node: root from flops, a fresh node is all zero, else last memory read
    always_comb
    begin
        if (node_reg == '0)
            cur = root_reg;
        else if (fresh_reg)
            cur = '0;
        else
            cur = rd_data_reg;
    end

    always_comb
    begin
        child       = addr_reg[ADDR_BITS-1] ? cur.right : cur.left;
        child_null  = (child == '0);
        pool_full   = (free_reg == FREE_BITS'(NODE_COUNT));
        at_end      = (level_reg == len_reg);
        lookup_done = (level_reg == LEN_BITS'(MAX_DEPTH)) || child_null;
        hit_now     = cur.valid;
        walk_hit    = hit_reg | hit_now;
        walk_port   = hit_now ? cur.port : best_reg;
        done        = (kind_reg == KIND_INSERT) ? (at_end || (child_null && pool_full))
                                                : lookup_done;
        sts.done    = done;
        wr_en       = cmd.step && (kind_reg == KIND_INSERT) && (at_end || child_null);
        move        = cmd.step && !done;
        rd_en       = move && !child_null;
    end

    // word written back to the current node on an insert
    always_comb
    begin
        wr_data = cur;
        if (at_end)
        begin
            wr_data.valid = 1'b1;
            wr_data.port  = port_reg;
        end
        else if (!pool_full)
        begin
            if (addr_reg[ADDR_BITS-1])
                wr_data.right = free_reg[NODE_BITS-1:0];
            else
                wr_data.left  = free_reg[NODE_BITS-1:0];
        end
    end

    always_comb
    begin
        root_next   = root_reg;
        free_next   = free_reg;
        node_next   = node_reg;
        fresh_next  = fresh_reg;
        level_next  = level_reg;
        len_next    = len_reg;
        addr_next   = addr_reg;
        kind_next   = kind_reg;
        port_next   = port_reg;
        hit_next    = hit_reg;
        best_next   = best_reg;
        result_next = result_reg;
        if (cmd.start)
        begin
            kind_next  = item.kind;
            addr_next  = item.address;
            len_next   = (item.prefix_length > LEN_BITS'(MAX_DEPTH)) ? LEN_BITS'(MAX_DEPTH)
                                                                     : item.prefix_length;
            port_next  = item.port[PORT_BITS-1:0];
            node_next  = '0;
            fresh_next = 1'b0;
            level_next = '0;
            hit_next   = 1'b0;
            best_next  = '0;
        end
        else if (cmd.step)
        begin
            hit_next  = walk_hit;
            best_next = walk_port;
            if (wr_en && node_reg == '0)
                root_next = wr_data;
            if (done)
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    result_next.found    = 1'b0;
                    result_next.out_port = '0;
                    result_next.status   = at_end ? STATUS_OK : STATUS_FULL;
                end
                else
                begin
                    result_next.found    = walk_hit;
                    result_next.out_port = OUT_BITS'(walk_port);
                    result_next.status   = STATUS_OK;
                end
            end
            else
            begin
                level_next = level_reg + LEN_BITS'(1);
                addr_next  = addr_reg << 1;
                if (child_null)
                begin
                    // allocate a new node, known to be all zero until written
                    node_next  = free_reg[NODE_BITS-1:0];
                    fresh_next = 1'b1;
                    free_next  = free_reg + FREE_BITS'(1);
                end
                else
                begin
                    node_next  = child;
                    fresh_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg  <= '0;
            free_reg  <= FREE_BITS'(1);
            node_reg  <= '0;
            fresh_reg <= 1'b0;
            level_reg <= '0;
            kind_reg  <= KIND_LOOKUP;
        end
        else
        begin
            root_reg  <= root_next;
            free_reg  <= free_next;
            node_reg  <= node_next;
            fresh_reg <= fresh_next;
            level_reg <= level_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        addr_reg   <= addr_next;
        port_reg   <= port_next;
        hit_reg    <= hit_next;
        best_reg   <= best_next;
        result_reg <= result_next;
    end

    // node pool: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en && node_reg != '0)
            mem[node_reg] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[child];
    end

    assign result = result_reg;

    free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg != '0 && free_reg <= FREE_BITS'(NODE_COUNT))
        else $error("free pointer out of range");

    node_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        FREE_BITS'(node_reg) < free_reg)
        else $error("walk reached an unallocated node");

endmodule

/* design/tlpm_ctrl.sv */
// tlpm_ctrl: walk sequencer and result beat handshake
// depends on tlpm_pkg; commands tlpm_datapath
module tlpm_ctrl
    import tlpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    output logic       result_valid,
    input  logic       result_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t sts
);

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   out_free;
    logic   finish;

    assign out_free = !(result_valid_reg && result_stall);
    assign finish   = cmd.step && sts.done;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.start  = item_valid;
            end
            ST_WALK:
            begin
                cmd.step = out_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    assign result_valid_next = finish || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == ST_WALK))
        else $error("accepted item did not start a walk");

    result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_WALK && sts.done))
        else $error("result beat raised without a finished walk");

    no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && result_valid_reg && result_stall) |=> (state_reg == ST_WALK))
        else $error("walk finished over a waiting result");

endmodule

/* design/trie_longest_prefix_match.sv */
// trie_longest_prefix_match: top level of the binary trie route table
// depends on tlpm_pkg, tlpm_ctrl and tlpm_datapath
//
// One item is worked at a time. The walk reads one trie node per cycle while no result beat
// waits, from a node pool of 4096 entries with a write port and a registered read port. An
// insert of prefix length L (capped at 32) descends L levels; a lookup descends until a child
// is null or 32 levels are passed. A new item is taken the cycle after the walk ends, even
// while its result beat is still stalled, and its walk pauses as long as that beat waits. The
// pool needs no clearing after reset; an insert needing a node from a full pool gets status 1.
module trie_longest_prefix_match
    import tlpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    tlpm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    tlpm_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule

/* tb/trie_longest_prefix_match_tb.sv */
// trie_longest_prefix_match_tb: self-checking bench for the binary trie route table
// needs tlpm_pkg and trie_longest_prefix_match; a trie model in the bench predicts
// every result beat while a negedge driver and a posedge monitor work the handshakes
`timescale 1ns / 100ps

module trie_longest_prefix_match_tb;
    import tlpm_pkg::*;

    localparam int RUN_LIMIT    = 500000;
    localparam int MAIN_ITEMS   = 480;
    localparam int TAIL_ITEMS   = 80;
    localparam int DRAIN_CYCLES = 40;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    trie_longest_prefix_match dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    // trie copy kept by the bench
    bit [NODE_BITS-1:0] left_link  [NODE_COUNT];
    bit [NODE_BITS-1:0] right_link [NODE_COUNT];
    bit                 node_valid [NODE_COUNT];
    bit [PORT_BITS-1:0] node_port  [NODE_COUNT];
    int unsigned        pool_next = 1;

    item_t       pending_items[$];
    result_t     expected_answers[$];
    int unsigned route_prefix[$];
    int unsigned route_len[$];
    int unsigned subnet_base[8];

    result_t     oldest_answer;
    result_t     fresh_answer;
    bit          took_item    = 1'b0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    int          stall_run    = 0;
    int          stall_pct    = 0;
    int unsigned cycle_count  = 0;
    int unsigned beats_in     = 0;
    int unsigned lookups      = 0;
    int unsigned lookup_hits  = 0;
    int unsigned inserts      = 0;
    int unsigned inserts_full = 0;
    int unsigned mismatches   = 0;

    function automatic result_t trie_answer(input item_t it);
        result_t            r;
        int unsigned        node;
        int unsigned        nxt;
        int unsigned        depth;
        int unsigned        lvl;
        bit                 go_right;
        bit                 hit;
        bit [PORT_BITS-1:0] best;
        r = '0;
        r.status = STATUS_OK;
        node = 0;
        if (it.kind == KIND_INSERT) begin
            depth = (it.prefix_length > MAX_DEPTH) ? MAX_DEPTH : it.prefix_length;
            for (lvl = 0; lvl < depth; lvl++) begin
                go_right = it.address[ADDR_BITS-1-lvl];
                nxt = go_right ? right_link[node] : left_link[node];
                if (nxt == 0) begin
                    if (pool_next >= NODE_COUNT) begin
                        r.status = STATUS_FULL;
                        return r;
                    end
                    nxt = pool_next;
                    pool_next++;
                    left_link[nxt]  = '0;
                    right_link[nxt] = '0;
                    node_valid[nxt] = 1'b0;
                    node_port[nxt]  = '0;
                    if (go_right)
                        right_link[node] = NODE_BITS'(nxt);
                    else
                        left_link[node] = NODE_BITS'(nxt);
                end
                node = nxt;
            end
            node_valid[node] = 1'b1;
            node_port[node]  = it.port[PORT_BITS-1:0];
        end
        else begin
            hit  = node_valid[0];
            best = node_valid[0] ? node_port[0] : '0;
            for (lvl = 0; lvl < MAX_DEPTH; lvl++) begin
                nxt = it.address[ADDR_BITS-1-lvl] ? right_link[node] : left_link[node];
                if (nxt == 0)
                    break;
                node = nxt;
                if (node_valid[node]) begin
                    hit  = 1'b1;
                    best = node_port[node];
                end
            end
            r.found    = hit;
            r.out_port = best;
        end
        return r;
    endfunction

    task automatic queue_item(input logic kind, input logic [ADDR_BITS-1:0] addr,
                              input int unsigned len, input logic [OUT_BITS-1:0] port);
        item_t it;
        it.kind          = kind;
        it.address       = addr;
        it.prefix_length = len[LEN_BITS-1:0];
        it.port          = port;
        pending_items.push_back(it);
        if (kind == KIND_INSERT) begin
            route_prefix.push_back(addr);
            route_len.push_back((len > MAX_DEPTH) ? MAX_DEPTH : len);
        end
    endtask

    task automatic queue_random_item(input bit root_ok);
        int unsigned pick;
        int unsigned sel;
        int unsigned idx;
        int unsigned addr;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            sel = $urandom_range(0, 99);
            if (sel < 10 && route_len.size() > 0) begin
                idx  = $urandom_range(0, route_len.size() - 1);
                addr = route_prefix[idx];
                len  = route_len[idx];
            end
            else begin
                if ($urandom_range(0, 3) == 0)
                    addr = $urandom;
                else
                    addr = subnet_base[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(4, 31));
                if (sel < 22)
                    len = MAX_DEPTH;
                else if (sel < 28)
                    len = $urandom_range(MAX_DEPTH + 1, 63);
                else if (root_ok && sel < 32)
                    len = 0;
                else
                    len = $urandom_range(1, 28);
            end
            queue_item(KIND_INSERT, addr, len, OUT_BITS'($urandom_range(0, 255)));
        end
        else begin
            if (pick < 85 && route_len.size() > 0) begin
                idx  = $urandom_range(0, route_len.size() - 1);
                addr = route_prefix[idx] ^ ($urandom >> route_len[idx]);
            end
            else if ($urandom_range(0, 1) == 0)
                addr = $urandom;
            else
                addr = subnet_base[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(4, 31));
            queue_item(KIND_LOOKUP, addr, $urandom_range(0, 63),
                       OUT_BITS'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain_inputs();
        while (pending_items.size() != 0 || item_valid)
            @(posedge clk);
    endtask

    // sender bursts and receiver stall pattern
    always @(negedge clk) begin
        if (rst_n) begin
            if (!item_valid || took_item) begin
                if (gap_left > 0) begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() > 0) begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
                else
                    item_valid <= 1'b0;
            end
            if (stall_run == 0) begin
                stall_run = $urandom_range(20, 300);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            stall_run--;
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                if (expected_answers.size() == 0) begin
                    $error("result beat with nothing pending: found %0d out_port %0d status %0d",
                           result.found, result.out_port, result.status);
                    mismatches++;
                end
                else begin
                    oldest_answer = expected_answers.pop_front();
                    if (result.found !== oldest_answer.found) begin
                        $error("found: expected %0d, got %0d", oldest_answer.found, result.found);
                        mismatches++;
                    end
                    if (result.out_port !== oldest_answer.out_port) begin
                        $error("out_port: expected %0d, got %0d",
                               oldest_answer.out_port, result.out_port);
                        mismatches++;
                    end
                    if (result.status !== oldest_answer.status) begin
                        $error("status: expected %0d, got %0d", oldest_answer.status, result.status);
                        mismatches++;
                    end
                end
            end
            if (item_valid && !item_stall) begin
                fresh_answer = trie_answer(item);
                expected_answers.push_back(fresh_answer);
                beats_in++;
                if (item.kind == KIND_LOOKUP) begin
                    lookups++;
                    if (fresh_answer.found)
                        lookup_hits++;
                end
                else begin
                    inserts++;
                    if (fresh_answer.status == STATUS_FULL)
                        inserts_full++;
                end
            end
            took_item <= item_valid && !item_stall;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        for (n = 0; n < 8; n++)
            subnet_base[n] = $urandom;

        // empty table, host routes, nesting, overwrite, over-long length
        queue_item(KIND_LOOKUP, 32'h0000_0000, 0, 8'h00);
        queue_item(KIND_LOOKUP, 32'hFFFF_FFFF, 63, 8'hFF);
        queue_item(KIND_INSERT, 32'hFFFF_FFFF, 32, 8'hFF);
        queue_item(KIND_LOOKUP, 32'hFFFF_FFFF, 0, 8'h00);
        queue_item(KIND_LOOKUP, 32'hFFFF_FFFE, 0, 8'h00);
        queue_item(KIND_INSERT, 32'h0A00_0000, 8, 8'h01);
        queue_item(KIND_LOOKUP, 32'h0A12_3456, 0, 8'h00);
        queue_item(KIND_INSERT, 32'h0A12_0000, 16, 8'h02);
        queue_item(KIND_LOOKUP, 32'h0A12_3456, 0, 8'h00);
        queue_item(KIND_LOOKUP, 32'h0A00_3456, 0, 8'h00);
        queue_item(KIND_INSERT, 32'h0A00_0000, 8, 8'h03);
        queue_item(KIND_LOOKUP, 32'h0A00_3456, 17, 8'h5C);
        queue_item(KIND_INSERT, 32'h0A12_0000, 63, 8'h04);
        queue_item(KIND_LOOKUP, 32'h0A12_0000, 0, 8'h00);
        queue_item(KIND_LOOKUP, 32'h0A12_0001, 0, 8'h00);
        // intermediate node made valid
        queue_item(KIND_INSERT, 32'h0000_0000, 4, 8'h07);
        queue_item(KIND_LOOKUP, 32'h0100_0000, 0, 8'h00);
        queue_item(KIND_INSERT, 32'h8000_0001, 33, 8'h80);
        queue_item(KIND_LOOKUP, 32'h8000_0001, 0, 8'h00);
        queue_item(KIND_LOOKUP, 32'h8000_0000, 0, 8'h00);
        queue_item(KIND_INSERT, 32'h0A12_3456, 32, 8'h00);
        queue_item(KIND_LOOKUP, 32'h0A12_3456, 0, 8'h00);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < MAIN_ITEMS; n++)
            queue_random_item(1'b0);
        drain_inputs();

        // host routes until the node pool runs out
        while (pool_next < NODE_COUNT) begin
            repeat (4)
                queue_item(KIND_INSERT, $urandom, 32, OUT_BITS'($urandom_range(0, 255)));
            drain_inputs();
        end
        repeat (6)
            queue_item(KIND_INSERT, $urandom, $urandom_range(20, 63),
                       OUT_BITS'($urandom_range(0, 255)));
        queue_item(KIND_INSERT, 32'hFFFF_FFFF, 32, 8'hC3);
        queue_item(KIND_LOOKUP, 32'hFFFF_FFFF, 0, 8'h00);

        // default route on a full pool
        queue_item(KIND_INSERT, $urandom, 0, 8'h5A);
        queue_item(KIND_LOOKUP, $urandom, 0, 8'h00);
        queue_item(KIND_INSERT, 32'h0000_0000, 0, 8'h00);
        queue_item(KIND_LOOKUP, $urandom, 0, 8'h00);
        for (n = 0; n < TAIL_ITEMS; n++)
            queue_random_item(1'b1);

        drain_inputs();
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d beats in: %0d lookups with %0d hits, %0d route inserts",
                 beats_in, lookups, lookup_hits, inserts);
        $display("%0d inserts refused after %0d trie nodes were used up",
                 inserts_full, pool_next);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
